/* sv/indexed_list_engine_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the indexed list engine
// Concurrent assertion wrappers; they compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_ENGINE_MACROS_SVH
`define INDEXED_LIST_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

// Assertion on an explicit clock and active-low reset
`define ILE_ASSERT_ON(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("indexed_list_engine: assertion failed");

// Assertion on the block clock and reset
`define ILE_ASSERT(lbl, prop) \
  `ILE_ASSERT_ON(lbl, clk_i, rst_ni, prop)

`else

`define ILE_ASSERT_ON(lbl, clk, rstn, prop)

`define ILE_ASSERT(lbl, prop)

`endif

`endif

/* sv/ile_pkg.sv */
// ----------------------------------------------------------------------------
// ile_pkg
// Shared types and codes of the indexed list engine.
// ----------------------------------------------------------------------------
package ile_pkg;

  typedef enum logic [3:0] {
    ACT_GET     = 4'd0,
    ACT_SET     = 4'd1,
    ACT_INSERT  = 4'd2,
    ACT_POP     = 4'd3,
    ACT_APPEND  = 4'd4,
    ACT_CLEAR   = 4'd5,
    ACT_COUNT   = 4'd6,
    ACT_INDEX   = 4'd7,
    ACT_REMOVE  = 4'd8,
    ACT_REVERSE = 4'd9,
    ACT_LENGTH  = 4'd10
  } action_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_RANGE     = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_FULL      = 2'd3
  } status_e;

  // What one cell does in a cycle
  typedef enum logic [2:0] {
    CELL_HOLD       = 3'd0,
    CELL_TAKE_LEFT  = 3'd1,
    CELL_TAKE_RIGHT = 3'd2,
    CELL_LOAD       = 3'd3,
    CELL_TAG_INIT   = 3'd4,
    CELL_SWAP_LEFT  = 3'd5,
    CELL_SWAP_RIGHT = 3'd6
  } cell_op_e;

  localparam int unsigned ResultValueWidth  = 32;
  localparam int unsigned ResultNumberWidth = 5;

  typedef struct packed {
    status_e                        status;
    logic [ResultValueWidth-1:0]    value;
    logic [ResultNumberWidth-1:0]   number;
  } result_t;

endpackage

/* sv/ile_bound.sv */
// ----------------------------------------------------------------------------
// ile_bound
// Wraps a signed list position by the length, clamps it to 0..length and
// flags whether it names an existing entry.
// ----------------------------------------------------------------------------
module ile_bound #(
  parameter int unsigned CW = 5
) (
  input  logic signed [31:0] pos_i,
  input  logic [CW-1:0]      n_i,
  output logic [CW-1:0]      clamp_o,
  output logic               in_range_o
);

  logic signed [33:0] pos_ext;
  logic signed [33:0] n_ext;
  logic signed [33:0] wrapped;
  logic               below;
  logic               above;

  assign pos_ext = {{2{pos_i[31]}}, pos_i};
  assign n_ext   = $signed({{(34-CW){1'b0}}, n_i});
  assign wrapped = pos_i[31] ? (pos_ext + n_ext) : pos_ext;
  assign below   = wrapped[33];
  assign above   = wrapped > n_ext;

  assign in_range_o = !below && (wrapped < n_ext);

  always_comb begin
    priority if (below) begin
      clamp_o = '0;
    end else if (above) begin
      clamp_o = n_i;
    end else begin
      clamp_o = wrapped[CW-1:0];
    end
  end

endmodule

/* sv/ile_cell.sv */
// ----------------------------------------------------------------------------
// ile_cell
// One list slot: a value word and an ordering tag, moved to and from its
// neighbors by a per-cycle command.
// ----------------------------------------------------------------------------
module ile_cell #(
  parameter int unsigned VW    = 32,
  parameter int unsigned TW    = 4,
  parameter int unsigned INDEX = 0
) (
  input  logic               clk_i,
  input  ile_pkg::cell_op_e  op_i,
  input  logic [VW-1:0]      load_i,
  input  logic [VW-1:0]      left_value_i,
  input  logic [VW-1:0]      right_value_i,
  input  logic [TW-1:0]      left_tag_i,
  input  logic [TW-1:0]      right_tag_i,
  output logic [VW-1:0]      value_o,
  output logic [TW-1:0]      tag_o
);

  import ile_pkg::*;

  logic [VW-1:0] value_q, value_d;
  logic [TW-1:0] tag_q, tag_d;

  // Swaps are compare-exchange on tags: the pair moves toward descending tag
  always_comb begin
    value_d = value_q;
    tag_d   = tag_q;
    unique case (op_i)
      CELL_HOLD: begin
      end
      CELL_TAKE_LEFT: begin
        value_d = left_value_i;
      end
      CELL_TAKE_RIGHT: begin
        value_d = right_value_i;
      end
      CELL_LOAD: begin
        value_d = load_i;
      end
      CELL_TAG_INIT: begin
        tag_d = TW'(INDEX);
      end
      CELL_SWAP_LEFT: begin
        if (left_tag_i < tag_q) begin
          value_d = left_value_i;
          tag_d   = left_tag_i;
        end
      end
      CELL_SWAP_RIGHT: begin
        if (tag_q < right_tag_i) begin
          value_d = right_value_i;
          tag_d   = right_tag_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    tag_q   <= tag_d;
  end

  assign value_o = value_q;
  assign tag_o   = tag_q;

endmodule

/* sv/indexed_list_engine.sv */
// ----------------------------------------------------------------------------
// indexed_list_engine
// Bounded ordered list of value words held in a ring of cells.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is accepted on a clock edge with start high and busy low;
//   action_i, position_i, stop_position_i and item_value_i are sampled then.
//   Exactly one result comes back: done_o is high for one cycle with
//   status_o, result_value_o and result_number_o valid in that cycle. The
//   receiver has no way to stall; it must take the result when done_o is up.
//   busy is high from the accept until the result is presented, and a new
//   transaction may be started in the same cycle that done_o is high.
// Steps after the accept:
//   length, clear, unused codes, errors ...... decode
//   set, insert, append ...................... decode, apply
//   get, pop, count, index, remove ........... decode, scan, apply
//   reverse .................................. decode, exchange rounds
//   Reads and searches rotate the whole ring once past cell 0, one step a
//   cycle; reverse runs one odd-even exchange round per entry.
// Reset clears the length and the control state; the stored words are not
// cleared and no request reads a slot at or beyond the length.
// ----------------------------------------------------------------------------
`include "indexed_list_engine_macros.svh"

module indexed_list_engine #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         action_i,
  input  logic signed [31:0] position_i,
  input  logic signed [31:0] stop_position_i,
  input  logic [31:0]        item_value_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [31:0]        result_value_o,
  output logic [4:0]         result_number_o
);

  import ile_pkg::*;

  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastStep = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCount = CW'(DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_APPLY,
    ST_SWAP
  } state_e;

  state_e             state_q, state_d;
  logic [3:0]         act_q, act_d;
  logic signed [31:0] pos_q, pos_d;
  logic signed [31:0] stop_q, stop_d;
  logic [VW-1:0]      val_q, val_d;
  logic [CW-1:0]      n_q, n_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      lo_q, lo_d;
  logic [CW-1:0]      hi_q, hi_d;
  logic [AW-1:0]      k_q, k_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               found_q, found_d;
  logic [CW-1:0]      round_q, round_d;
  logic [VW-1:0]      rval_q, rval_d;
  logic               done_q;
  result_t            res_q, res_d;

  logic               fin;
  logic               use_num;
  logic [CW-1:0]      fin_num;
  logic [CW-1:0]      num_sel;

  logic [CW-1:0]      pos_clamp, stop_clamp;
  logic               pos_ok;
  logic               stop_ok;
  logic [CW-1:0]      scan_pos;
  logic               match;

  logic [VW-1:0]      cell_value [DEPTH];
  logic [AW-1:0]      cell_tag   [DEPTH];

  ile_bound #(.CW(CW)) u_pos_bound (
    .pos_i      (pos_q),
    .n_i        (n_q),
    .clamp_o    (pos_clamp),
    .in_range_o (pos_ok)
  );

  ile_bound #(.CW(CW)) u_stop_bound (
    .pos_i      (stop_q),
    .n_i        (n_q),
    .clamp_o    (stop_clamp),
    .in_range_o (stop_ok)
  );

  // During a scan, cell 0 holds the entry whose list position is k_q
  assign scan_pos = CW'(k_q);
  assign match    = (cell_value[0] == val_q);

  always_comb begin
    state_d = state_q;
    act_d   = act_q;
    pos_d   = pos_q;
    stop_d  = stop_q;
    val_d   = val_q;
    n_d     = n_q;
    idx_d   = idx_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    found_d = found_q;
    round_d = round_q;
    rval_d  = rval_q;
    res_d   = res_q;
    fin     = 1'b0;
    use_num = 1'b0;
    fin_num = '0;
    res_d.status = res_q.status;
    res_d.value  = res_q.value;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          act_d   = action_i;
          pos_d   = position_i;
          stop_d  = stop_position_i;
          val_d   = VW'(item_value_i);
          state_d = ST_DECODE;
        end
      end

      ST_DECODE: begin
        k_d     = '0;
        cnt_d   = '0;
        found_d = 1'b0;
        round_d = '0;
        rval_d  = '0;
        idx_d   = pos_clamp;
        lo_d    = pos_clamp;
        hi_d    = stop_clamp;
        res_d.status = STATUS_OK;
        res_d.value  = '0;
        unique case (act_q)
          ACT_GET, ACT_POP: begin
            if (pos_ok) begin
              state_d = ST_SCAN;
            end else begin
              fin          = 1'b1;
              res_d.status = STATUS_RANGE;
            end
          end
          ACT_SET: begin
            if (pos_ok) begin
              state_d = ST_APPLY;
            end else begin
              fin          = 1'b1;
              res_d.status = STATUS_RANGE;
            end
          end
          ACT_INSERT, ACT_APPEND: begin
            if (n_q == FullCount) begin
              fin          = 1'b1;
              res_d.status = STATUS_FULL;
            end else begin
              state_d = ST_APPLY;
            end
          end
          ACT_CLEAR: begin
            n_d = '0;
            fin = 1'b1;
          end
          ACT_COUNT, ACT_INDEX: begin
            state_d = ST_SCAN;
          end
          ACT_REMOVE: begin
            lo_d    = '0;
            hi_d    = n_q;
            state_d = ST_SCAN;
          end
          ACT_REVERSE: begin
            state_d = ST_SWAP;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end

      ST_SCAN: begin
        if ((act_q == ACT_GET || act_q == ACT_POP) && scan_pos == idx_q) begin
          rval_d = cell_value[0];
        end
        if (act_q == ACT_COUNT && scan_pos < n_q && match) begin
          cnt_d = cnt_q + CW'(1);
        end
        if ((act_q == ACT_INDEX || act_q == ACT_REMOVE) && !found_q &&
            scan_pos >= lo_q && scan_pos < hi_q && match) begin
          found_d = 1'b1;
          idx_d   = scan_pos;
        end
        if (k_q == LastStep) begin
          state_d = ST_APPLY;
        end else begin
          k_d = k_q + AW'(1);
        end
      end

      ST_APPLY: begin
        fin = 1'b1;
        unique case (act_q)
          ACT_GET: begin
            res_d.value = ResultValueWidth'(rval_q);
          end
          ACT_INSERT, ACT_APPEND: begin
            n_d = n_q + CW'(1);
          end
          ACT_POP: begin
            n_d         = n_q - CW'(1);
            res_d.value = ResultValueWidth'(rval_q);
          end
          ACT_COUNT: begin
            use_num = 1'b1;
            fin_num = cnt_q;
          end
          ACT_INDEX: begin
            use_num = 1'b1;
            fin_num = found_q ? idx_q : '0;
            if (!found_q) begin
              res_d.status = STATUS_NOT_FOUND;
            end
          end
          ACT_REMOVE: begin
            if (found_q) begin
              n_d = n_q - CW'(1);
            end else begin
              res_d.status = STATUS_NOT_FOUND;
            end
          end
          default: begin
          end
        endcase
      end

      ST_SWAP: begin
        if (round_q == n_q) begin
          fin = 1'b1;
        end else begin
          round_d = round_q + CW'(1);
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (fin) begin
      state_d = ST_IDLE;
    end
    num_sel      = use_num ? fin_num : n_d;
    res_d.number = ResultNumberWidth'(num_sel);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      n_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      done_q  <= fin;
      act_q   <= act_d;
      pos_q   <= pos_d;
      stop_q  <= stop_d;
      val_q   <= val_d;
      idx_q   <= idx_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
      found_q <= found_d;
      round_q <= round_d;
      rval_q  <= rval_d;
      res_q   <= res_d;
    end
  end

  // Ring of cells; cell i holds list position i outside of scans
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CW-1:0] Idx     = CW'(i);
    localparam logic [CW-1:0] IdxNext = CW'(i + 1);
    localparam logic          Odd     = 1'((i % 2) == 1);
    localparam bit            HasLeft = (i != 0);

    cell_op_e op;

    always_comb begin
      op = CELL_HOLD;
      unique case (state_q)
        ST_DECODE: begin
          if (act_q == ACT_REVERSE) begin
            op = CELL_TAG_INIT;
          end
        end
        ST_SCAN: begin
          op = CELL_TAKE_RIGHT;
        end
        ST_APPLY: begin
          unique case (act_q)
            ACT_SET: begin
              if (Idx == idx_q) begin
                op = CELL_LOAD;
              end
            end
            ACT_INSERT: begin
              if (Idx == idx_q) begin
                op = CELL_LOAD;
              end else if (Idx > idx_q) begin
                op = CELL_TAKE_LEFT;
              end
            end
            ACT_APPEND: begin
              if (Idx == n_q) begin
                op = CELL_LOAD;
              end
            end
            ACT_POP: begin
              if (Idx >= idx_q) begin
                op = CELL_TAKE_RIGHT;
              end
            end
            ACT_REMOVE: begin
              if (found_q && Idx >= idx_q) begin
                op = CELL_TAKE_RIGHT;
              end
            end
            default: begin
            end
          endcase
        end
        ST_SWAP: begin
          // Odd-even exchange: pairs start on even cells in even rounds
          if (round_q != n_q) begin
            if (Odd == round_q[0] && IdxNext < n_q) begin
              op = CELL_SWAP_RIGHT;
            end else if (Odd != round_q[0] && HasLeft && Idx < n_q) begin
              op = CELL_SWAP_LEFT;
            end
          end
        end
        default: begin
        end
      endcase
    end

    ile_cell #(
      .VW    (VW),
      .TW    (AW),
      .INDEX (i)
    ) u_cell (
      .clk_i         (clk_i),
      .op_i          (op),
      .load_i        (val_q),
      .left_value_i  (cell_value[(i + DEPTH - 1) % DEPTH]),
      .right_value_i (cell_value[(i + 1) % DEPTH]),
      .left_tag_i    (cell_tag[(i + DEPTH - 1) % DEPTH]),
      .right_tag_i   (cell_tag[(i + 1) % DEPTH]),
      .value_o       (cell_value[i]),
      .tag_o         (cell_tag[i])
    );
  end

  assign busy            = (state_q != ST_IDLE);
  assign done_o          = done_q;
  assign status_o        = res_q.status;
  assign result_value_o  = res_q.value;
  assign result_number_o = res_q.number;

  `ILE_ASSERT(a_len_bound, n_q <= FullCount)
  `ILE_ASSERT(a_strobe_single, done_q |=> !done_q)
  `ILE_ASSERT(a_strobe_idle, done_q |-> !busy)
  `ILE_ASSERT(a_full_len, done_q && res_q.status == STATUS_FULL |-> n_q == FullCount)
  `ILE_ASSERT(a_accept_busy, start && !busy |=> busy && !done_q)

endmodule

/* test/tb_indexed_list_engine.sv */
// ----------------------------------------------------------------------------
// tb_indexed_list_engine
// Self-checking bench for the indexed list engine. A short table of directed
// requests walks through empty-list errors, position extremes and every
// action; then about 1800 random requests run in grow, shrink and even
// phases, issued in bursts with random gaps. Every answer is checked field
// by field against a typed table answer or the behavioral list in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_indexed_list_engine;
  import ile_pkg::*;

  localparam int          LIST_DEPTH     = 16;
  localparam int          RANDOM_ITEMS   = 1830;
  localparam int          DRAIN_CYCLES   = 2 * LIST_DEPTH + 8;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam logic [3:0]  ACT_UNUSED_LO  = 4'd11;
  localparam logic [3:0]  ACT_UNUSED_HI  = 4'd15;
  localparam bit          FROM_MODEL     = 1'b0;
  localparam bit          TYPED          = 1'b1;

  typedef enum int {MIX_EVEN, MIX_GROW, MIX_SHRINK} mix_e;

  typedef struct {
    logic [3:0]  act;
    logic [31:0] pos;
    logic [31:0] stop;
    logic [31:0] val;
    bit          typed;
    result_t     want;
  } plan_row_t;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        start         = 1'b0;
  logic        busy;
  logic [3:0]  action        = '0;
  logic [31:0] position      = '0;
  logic [31:0] stop_position = '0;
  logic [31:0] item_value    = '0;
  logic        done;
  logic [1:0]  status;
  logic [31:0] result_value;
  logic [4:0]  result_number;

  // typed answer travelling with a directed transaction
  bit          row_typed     = 1'b0;
  result_t     row_want      = '0;

  logic [31:0] list_words [LIST_DEPTH];
  int          list_len = 0;
  result_t     answers_due [$];
  plan_row_t   plan [$];
  int          fail_count = 0;
  int          quiet_cycles = 0;

  indexed_list_engine #(
    .DEPTH      (LIST_DEPTH),
    .VALUE_WIDTH(32)
  ) uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .action_i       (action),
    .position_i     (position),
    .stop_position_i(stop_position),
    .item_value_i   (item_value),
    .done_o         (done),
    .status_o       (status),
    .result_value_o (result_value),
    .result_number_o(result_number)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---- behavioral list -----------------------------------------------------

  function automatic bit wrap_in(input logic signed [31:0] p, output int idx);
    longint q;
    q = p;
    if (q < 0) q += list_len;
    idx = int'(q);
    return (q >= 0) && (q < list_len);
  endfunction

  function automatic int clamp_to_len(input logic signed [31:0] p);
    longint q;
    q = p;
    if (q < 0) q += list_len;
    if (q < 0) q = 0;
    if (q > list_len) q = list_len;
    return int'(q);
  endfunction

  function automatic void drop_at(input int idx);
    for (int i = idx; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
    list_len--;
  endfunction

  // Applies one request to the list and returns the answer it gives.
  function automatic result_t list_answer(input logic [3:0] act,
                                          input logic signed [31:0] pos,
                                          input logic signed [31:0] stop,
                                          input logic [31:0] val);
    result_t     r;
    int          idx;
    int          lo;
    int          hi;
    bit          num_set;
    bit          found;
    logic [31:0] tmp;
    r = '0;
    r.status = STATUS_OK;
    num_set = 1'b0;
    found = 1'b0;
    idx = 0;
    case (act)
      ACT_GET: begin
        if (wrap_in(pos, idx)) r.value = list_words[idx];
        else r.status = STATUS_RANGE;
      end
      ACT_SET: begin
        if (wrap_in(pos, idx)) list_words[idx] = val;
        else r.status = STATUS_RANGE;
      end
      ACT_INSERT: begin
        if (list_len >= LIST_DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          idx = clamp_to_len(pos);
          for (int i = list_len; i > idx; i--) list_words[i] = list_words[i - 1];
          list_words[idx] = val;
          list_len++;
        end
      end
      ACT_POP: begin
        if (wrap_in(pos, idx)) begin
          r.value = list_words[idx];
          drop_at(idx);
        end else begin
          r.status = STATUS_RANGE;
        end
      end
      ACT_APPEND: begin
        if (list_len >= LIST_DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          list_words[list_len] = val;
          list_len++;
        end
      end
      ACT_CLEAR: list_len = 0;
      ACT_COUNT: begin
        for (int i = 0; i < list_len; i++)
          if (list_words[i] == val) r.number++;
        num_set = 1'b1;
      end
      ACT_INDEX: begin
        lo = clamp_to_len(pos);
        hi = clamp_to_len(stop);
        r.status = STATUS_NOT_FOUND;
        for (int i = lo; i < hi; i++) begin
          if (!found && list_words[i] == val) begin
            found = 1'b1;
            r.status = STATUS_OK;
            r.number = 5'(i);
          end
        end
        num_set = 1'b1;
      end
      ACT_REMOVE: begin
        r.status = STATUS_NOT_FOUND;
        for (int i = 0; i < list_len; i++) begin
          if (!found && list_words[i] == val) begin
            found = 1'b1;
            drop_at(i);
            r.status = STATUS_OK;
          end
        end
      end
      ACT_REVERSE: begin
        for (int i = 0; i < list_len / 2; i++) begin
          tmp = list_words[i];
          list_words[i] = list_words[list_len - 1 - i];
          list_words[list_len - 1 - i] = tmp;
        end
      end
      default: ;
    endcase
    if (!num_set) r.number = 5'(list_len);
    return r;
  endfunction

  // ---- answer checking -----------------------------------------------------

  always @(posedge clk) begin : scoreboard
    result_t want;
    result_t predicted;
    if (rst_n) begin
      if (done) begin
        if (answers_due.size() == 0) begin
          fail_count++;
          $error("answer strobe with no transaction outstanding");
        end else begin
          want = answers_due.pop_front();
          if (status !== 2'(want.status)) begin
            fail_count++;
            $error("status: expected %0d, got %0d", want.status, status);
          end
          if (result_value !== want.value) begin
            fail_count++;
            $error("result_value: expected %h, got %h", want.value, result_value);
          end
          if (result_number !== want.number) begin
            fail_count++;
            $error("result_number: expected %0d, got %0d", want.number, result_number);
          end
        end
      end
      if (start && !busy) begin
        predicted = list_answer(action, position, stop_position, item_value);
        answers_due.push_back(row_typed ? row_want : predicted);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---- stimulus ------------------------------------------------------------

  function automatic void plan_row(input logic [3:0] act, input logic [31:0] pos,
                                   input logic [31:0] stop, input logic [31:0] val,
                                   input bit typed, input status_e st,
                                   input logic [31:0] rv, input logic [4:0] rn);
    plan_row_t row;
    row.act  = act;
    row.pos  = pos;
    row.stop = stop;
    row.val  = val;
    row.typed = typed;
    row.want.status = st;
    row.want.value  = rv;
    row.want.number = rn;
    plan.push_back(row);
  endfunction

  function automatic logic [3:0] pick_action(input mix_e mix);
    int          w;
    logic [3:0]  a;
    w = $urandom_range(0, 99);
    if (mix == MIX_GROW && w < 60) return (w < 30) ? ACT_APPEND : ACT_INSERT;
    if (mix == MIX_SHRINK && w < 50) return (w < 25) ? ACT_POP : ACT_REMOVE;
    w = $urandom_range(0, 99);
    if (w < 3) return 4'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
    if (w < 6) return ACT_CLEAR;
    // clear is kept rare so the list gets a chance to fill
    a = 4'($urandom_range(0, 9));
    if (a >= ACT_CLEAR) a++;
    return a;
  endfunction

  function automatic logic [31:0] pick_position();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return $urandom;
      default: return 32'(int'($urandom_range(0, 40)) - 20);
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return $urandom_range(1, 3);
      default: return $urandom;
    endcase
  endfunction

  // Call right after a rising edge; returns at the edge that takes the transaction.
  task automatic issue(input logic [3:0] act, input logic [31:0] pos,
                       input logic [31:0] stop, input logic [31:0] val,
                       input bit typed, input result_t want);
    start         <= 1'b1;
    action        <= act;
    position      <= pos;
    stop_position <= stop;
    item_value    <= val;
    row_typed     <= typed;
    row_want      <= want;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    do @(negedge clk); while (answers_due.size() != 0);
    @(posedge clk);
  endtask

  initial begin
    mix_e mix;
    int   burst_left;
    int   gap;
    mix = MIX_GROW;
    burst_left = 0;

    plan_row(ACT_LENGTH,    0,            0, 0,            TYPED, STATUS_OK, 0, 0);
    plan_row(ACT_GET,       0,            0, 0,            TYPED, STATUS_RANGE, 0, 0);
    plan_row(ACT_POP,       32'hFFFF_FFFF, 0, 0,           TYPED, STATUS_RANGE, 0, 0);
    plan_row(ACT_REVERSE,   0,            0, 0,            TYPED, STATUS_OK, 0, 0);
    plan_row(ACT_INDEX,     0,            0, 0,            TYPED, STATUS_NOT_FOUND, 0, 0);
    plan_row(ACT_REMOVE,    0,            0, 5,            TYPED, STATUS_NOT_FOUND, 0, 0);
    plan_row(ACT_APPEND,    0,            0, 32'hFFFF_FFFF, TYPED, STATUS_OK, 0, 1);
    plan_row(ACT_APPEND,    0,            0, 0,            TYPED, STATUS_OK, 0, 2);
    plan_row(ACT_INSERT,    32'h8000_0000, 0, 32'h1234_5678, TYPED, STATUS_OK, 0, 3);
    plan_row(ACT_INSERT,    32'h7FFF_FFFF, 0, 32'hA5A5_A5A5, TYPED, STATUS_OK, 0, 4);
    plan_row(ACT_GET,       32'hFFFF_FFFF, 0, 0,           FROM_MODEL, STATUS_OK, 0, 0);
    plan_row(ACT_GET,       32'h8000_0000, 0, 0,           TYPED, STATUS_RANGE, 0, 4);
    plan_row(ACT_GET,       32'h7FFF_FFFF, 0, 0,           TYPED, STATUS_RANGE, 0, 4);
    plan_row(ACT_SET,       32'hFFFF_FFFC, 0, 32'hDEAD_BEEF, FROM_MODEL, STATUS_OK, 0, 0);
    plan_row(ACT_COUNT,     0,            0, 0,            FROM_MODEL, STATUS_OK, 0, 0);
    plan_row(ACT_INDEX,     32'hFFFF_FFFD, 32'h7FFF_FFFF, 0, FROM_MODEL, STATUS_OK, 0, 0);
    // start bound past stop: nothing searched
    plan_row(ACT_INDEX,     3,            1, 0,            TYPED, STATUS_NOT_FOUND, 0, 0);
    plan_row(ACT_REVERSE,   0,            0, 0,            FROM_MODEL, STATUS_OK, 0, 0);
    plan_row(ACT_POP,       0,            0, 0,            FROM_MODEL, STATUS_OK, 0, 0);
    plan_row(ACT_REMOVE,    0,            0, 32'hFFFF_FFFF, FROM_MODEL, STATUS_OK, 0, 0);
    plan_row(ACT_UNUSED_HI, 32'h7FFF_FFFF, 32'h8000_0000, '1, FROM_MODEL, STATUS_OK, 0, 0);
    plan_row(ACT_UNUSED_LO, 0,            0, 0,            FROM_MODEL, STATUS_OK, 0, 0);
    plan_row(ACT_CLEAR,     0,            0, 0,            TYPED, STATUS_OK, 0, 0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i])
      issue(plan[i].act, plan[i].pos, plan[i].stop, plan[i].val, plan[i].typed,
            plan[i].want);
    hold_until_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) == 0) mix = mix_e'($urandom_range(0, 2));
      end
      if (n == RANDOM_ITEMS / 2) hold_until_drained();
      issue(pick_action(mix), pick_position(), pick_position(), pick_value(),
            FROM_MODEL, '0);
      burst_left--;
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/ile_pkg.sv
sv/ile_bound.sv
sv/ile_cell.sv
sv/indexed_list_engine.sv
test/tb_indexed_list_engine.sv
